// ----- sv/tld_pkg.sv -----
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types, codes and defaults for the cooked terminal line discipline.
// ----------------------------------------------------------------------------
package tld_pkg;

   localparam int IN_DEPTH_DEF  = 256;
   localparam int OUT_DEPTH_DEF = 256;
   localparam int LINE_MAX_DEF  = 64;

   localparam logic [1:0] OP_KEY   = 2'd0;
   localparam logic [1:0] OP_HOST  = 2'd1;
   localparam logic [1:0] OP_READ  = 2'd2;
   localparam logic [1:0] OP_DRAIN = 2'd3;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_LINE   = 2'd1;
   localparam logic [1:0] KIND_OUT    = 2'd2;
   localparam logic [1:0] KIND_EMPTY  = 2'd3;

   localparam logic [2:0] REG_ECHO_ENABLE   = 3'd0;
   localparam logic [2:0] REG_OUT_CRLF      = 3'd1;
   localparam logic [2:0] REG_IN_NL_TO_CRNL = 3'd2;
   localparam logic [2:0] REG_EOF_ENABLE    = 3'd3;
   localparam logic [2:0] REG_EOF_CHAR      = 3'd4;

   localparam logic [7:0] CH_BS = 8'h08;
   localparam logic [7:0] CH_LF = 8'h0A;
   localparam logic [7:0] CH_CR = 8'h0D;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] data_byte;
      logic [6:0] read_limit;
   } tld_req_type;

   typedef struct packed {
      logic [1:0] result_kind;
      logic [7:0] out_byte;
      logic       status;
      logic       last;
   } tld_rsp_type;

   // decoded command held in the queue between front and back
   typedef struct packed {
      logic [1:0] op;
      logic [7:0] data_byte;
      logic       is_lf;
      logic [6:0] limit;
   } tld_cmd_type;

   typedef struct packed {
      logic       echo_enable;
      logic       out_crlf;
      logic       in_nl_to_crnl;
      logic       eof_enable;
      logic [7:0] eof_char;
   } tld_cfg_type;

endpackage

// ----- sv/tld_front.sv -----
// ----------------------------------------------------------------------------
// tld_front
// Accepts request transactions, decodes them and queues them for the back end.
// ----------------------------------------------------------------------------
module tld_front #(
   parameter int LINE_MAX = tld_pkg::LINE_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tld_pkg::tld_req_type req_data,
   output logic                 cmd_valid,
   input  logic                 cmd_pop,
   output tld_pkg::tld_cmd_type cmd_data
);

   tld_pkg::tld_cmd_type q_ff [2];
   tld_pkg::tld_cmd_type cmd_new;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign req_stall = (count_ff == 2'd2);
   assign push      = req_valid && !req_stall;
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];

   always_comb begin
      cmd_new.op        = req_data.req_type;
      cmd_new.data_byte = req_data.data_byte;
      cmd_new.is_lf     = (req_data.data_byte == tld_pkg::CH_LF);
      // saturate the read limit at the line size
      if (req_data.read_limit > 7'(LINE_MAX)) begin
         cmd_new.limit = 7'(LINE_MAX);
      end else begin
         cmd_new.limit = req_data.read_limit;
      end
   end

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

endmodule

// ----- sv/tld_back.sv -----
// ----------------------------------------------------------------------------
// tld_back
// Executes queued commands against the input ring, output ring and line store.
// ----------------------------------------------------------------------------
module tld_back #(
   parameter int IN_DEPTH  = tld_pkg::IN_DEPTH_DEF,
   parameter int OUT_DEPTH = tld_pkg::OUT_DEPTH_DEF,
   parameter int LINE_MAX  = tld_pkg::LINE_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tld_pkg::tld_cfg_type cfg,
   input  logic                 cmd_valid,
   output logic                 cmd_pop,
   input  tld_pkg::tld_cmd_type cmd_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tld_pkg::tld_rsp_type rsp_data
);

   localparam int IPW = $clog2(IN_DEPTH);
   localparam int IFW = $clog2(IN_DEPTH + 1);
   localparam int OPW = $clog2(OUT_DEPTH);
   localparam int OFW = $clog2(OUT_DEPTH + 1);
   localparam int LW  = $clog2(LINE_MAX);
   localparam int LNW = $clog2(LINE_MAX + 1);

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_ECHO2   = 4'd1;
   localparam logic [3:0] S_HOST2   = 4'd2;
   localparam logic [3:0] S_RUN     = 4'd3;
   localparam logic [3:0] S_RR2     = 4'd4;
   localparam logic [3:0] S_RR3     = 4'd5;
   localparam logic [3:0] S_EMIT    = 4'd6;
   localparam logic [3:0] S_EMIT_RD = 4'd7;
   localparam logic [3:0] S_EMIT_WR = 4'd8;
   localparam logic [3:0] S_DRAIN2  = 4'd9;

   logic [3:0]     state_ff, state_in;
   tld_pkg::tld_cmd_type cmd_ff, cmd_in;
   logic [IPW-1:0] in_rp_ff, in_rp_in, in_wp_ff, in_wp_in;
   logic [IFW-1:0] in_fill_ff, in_fill_in;
   logic [OPW-1:0] out_rp_ff, out_rp_in, out_wp_ff, out_wp_in;
   logic [OFW-1:0] out_fill_ff, out_fill_in;
   logic [LNW-1:0] line_len_ff, line_len_in, read_max_ff, read_max_in;
   logic [LW-1:0]  idx_ff, idx_in;
   logic           pending_ff, pending_in;
   logic           rsp_valid_ff, rsp_valid_in;
   tld_pkg::tld_rsp_type rsp_ff, rsp_in;

   logic [7:0]     in_ring_ff   [IN_DEPTH];
   logic [7:0]     out_ring_ff  [OUT_DEPTH];
   logic [7:0]     line_ff      [LINE_MAX];
   logic [7:0]     in_rd_ff, out_rd_ff, line_rd_ff;

   logic           in_we, in_re, out_we, out_re, line_we, line_re;
   logic [7:0]     out_wd, line_wd;
   logic [LW-1:0]  line_wa;
   logic           go, out_room, in_full, ends;
   logic [7:0]     ch;

   assign go        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_room  = (out_fill_ff < OFW'(OUT_DEPTH));
   assign in_full   = (in_fill_ff == IFW'(IN_DEPTH));
   assign ch        = in_rd_ff;
   assign ends      = (cfg.eof_enable && (ch == cfg.eof_char)) ||
                      (ch == tld_pkg::CH_CR) || (ch == tld_pkg::CH_LF);

   function automatic tld_pkg::tld_rsp_type mk_rsp(logic [1:0] kind, logic [7:0] b,
                                                   logic st, logic lst);
      tld_pkg::tld_rsp_type r;
      r.result_kind = kind;
      r.out_byte    = b;
      r.status      = st;
      r.last        = lst;
      return r;
   endfunction

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      in_rp_in     = in_rp_ff;
      in_wp_in     = in_wp_ff;
      in_fill_in   = in_fill_ff;
      out_rp_in    = out_rp_ff;
      out_wp_in    = out_wp_ff;
      out_fill_in  = out_fill_ff;
      line_len_in  = line_len_ff;
      read_max_in  = read_max_ff;
      idx_in       = idx_ff;
      pending_in   = pending_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      cmd_pop      = 1'b0;
      in_we        = 1'b0;
      in_re        = 1'b0;
      out_we       = 1'b0;
      out_wd       = cmd_ff.data_byte;
      out_re       = 1'b0;
      line_we      = 1'b0;
      line_wd      = ch;
      line_wa      = line_len_ff[LW-1:0];
      line_re      = 1'b0;
      if (go) begin
         case (state_ff)
            S_IDLE: begin
               if (cmd_valid) begin
                  cmd_pop = 1'b1;
                  cmd_in  = cmd_data;
                  out_wd  = cmd_data.data_byte;
                  case (cmd_data.op)
                     tld_pkg::OP_KEY: begin
                        if (in_full) begin
                           rsp_valid_in = 1'b1;
                           rsp_in = mk_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b1, 1'b1);
                        end else begin
                           in_we      = 1'b1;
                           in_wp_in   = (in_wp_ff == IPW'(IN_DEPTH - 1)) ? '0 : in_wp_ff + 1'b1;
                           in_fill_in = in_fill_ff + 1'b1;
                           if (cfg.echo_enable) begin
                              if (cmd_data.is_lf && cfg.out_crlf) begin
                                 out_wd = tld_pkg::CH_CR;
                              end
                              out_we = out_room;
                           end
                           if (cfg.echo_enable && cmd_data.is_lf && cfg.out_crlf) begin
                              state_in = S_ECHO2;
                           end else if (pending_ff) begin
                              state_in = S_RUN;
                           end else begin
                              rsp_valid_in = 1'b1;
                              rsp_in = mk_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b0, 1'b1);
                           end
                        end
                     end
                     tld_pkg::OP_HOST: begin
                        if (cmd_data.is_lf && cfg.out_crlf) begin
                           if (out_room) begin
                              out_we   = 1'b1;
                              out_wd   = tld_pkg::CH_CR;
                              state_in = S_HOST2;
                           end else begin
                              rsp_valid_in = 1'b1;
                              rsp_in = mk_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b1, 1'b1);
                           end
                        end else begin
                           out_we       = out_room;
                           rsp_valid_in = 1'b1;
                           rsp_in = mk_rsp(tld_pkg::KIND_STATUS, 8'd0, !out_room, 1'b1);
                        end
                     end
                     tld_pkg::OP_READ: begin
                        if (pending_ff) begin
                           rsp_valid_in = 1'b1;
                           rsp_in = mk_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b1, 1'b1);
                        end else begin
                           pending_in  = 1'b1;
                           read_max_in = LNW'(cmd_data.limit);
                           line_len_in = '0;
                           state_in    = S_RUN;
                        end
                     end
                     default: begin
                        if (out_fill_ff == '0) begin
                           rsp_valid_in = 1'b1;
                           rsp_in = mk_rsp(tld_pkg::KIND_EMPTY, 8'd0, 1'b0, 1'b1);
                        end else begin
                           out_re      = 1'b1;
                           out_rp_in   = (out_rp_ff == OPW'(OUT_DEPTH - 1)) ? '0 : out_rp_ff + 1'b1;
                           out_fill_in = out_fill_ff - 1'b1;
                           state_in    = S_DRAIN2;
                        end
                     end
                  endcase
                  if (out_we) begin
                     out_wp_in   = (out_wp_ff == OPW'(OUT_DEPTH - 1)) ? '0 : out_wp_ff + 1'b1;
                     out_fill_in = out_fill_ff + 1'b1;
                  end
               end
            end
            S_ECHO2, S_HOST2: begin
               out_we = out_room;
               out_wd = tld_pkg::CH_LF;
               if (out_room) begin
                  out_wp_in   = (out_wp_ff == OPW'(OUT_DEPTH - 1)) ? '0 : out_wp_ff + 1'b1;
                  out_fill_in = out_fill_ff + 1'b1;
               end
               if (state_ff == S_HOST2) begin
                  rsp_valid_in = 1'b1;
                  rsp_in   = mk_rsp(tld_pkg::KIND_STATUS, 8'd0, !out_room, 1'b1);
                  state_in = S_IDLE;
               end else if (pending_ff) begin
                  state_in = S_RUN;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_in   = mk_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b0, 1'b1);
                  state_in = S_IDLE;
               end
            end
            S_RUN: begin
               if (line_len_ff >= read_max_ff) begin
                  state_in = S_EMIT;
               end else if (in_fill_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in   = mk_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b0, 1'b1);
                  state_in = S_IDLE;
               end else begin
                  in_re      = 1'b1;
                  in_rp_in   = (in_rp_ff == IPW'(IN_DEPTH - 1)) ? '0 : in_rp_ff + 1'b1;
                  in_fill_in = in_fill_ff - 1'b1;
                  state_in   = S_RR2;
               end
            end
            S_RR2: begin
               if (ch == tld_pkg::CH_BS && line_len_ff != '0) begin
                  line_len_in = line_len_ff - 1'b1;
                  state_in    = S_RUN;
               end else if (ch == tld_pkg::CH_BS) begin
                  state_in = ends ? S_EMIT : S_RUN;
               end else if (ch == tld_pkg::CH_LF && cfg.in_nl_to_crnl &&
                            (line_len_ff + 1'b1 < read_max_ff)) begin
                  line_we     = 1'b1;
                  line_wd     = tld_pkg::CH_CR;
                  line_len_in = line_len_ff + 1'b1;
                  state_in    = S_RR3;
               end else begin
                  line_we     = 1'b1;
                  line_len_in = line_len_ff + 1'b1;
                  state_in    = ends ? S_EMIT : S_RUN;
               end
            end
            S_RR3: begin
               line_we     = 1'b1;
               line_wd     = tld_pkg::CH_LF;
               line_len_in = line_len_ff + 1'b1;
               state_in    = S_EMIT;
            end
            S_EMIT: begin
               pending_in = 1'b0;
               idx_in     = '0;
               if (line_len_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in   = mk_rsp(tld_pkg::KIND_EMPTY, 8'd0, 1'b0, 1'b1);
                  state_in = S_IDLE;
               end else begin
                  state_in = S_EMIT_RD;
               end
            end
            S_EMIT_RD: begin
               line_re  = 1'b1;
               state_in = S_EMIT_WR;
            end
            S_EMIT_WR: begin
               rsp_valid_in = 1'b1;
               rsp_in = mk_rsp(tld_pkg::KIND_LINE, line_rd_ff, 1'b0,
                               (LNW'(idx_ff) + 1'b1 == line_len_ff));
               if (LNW'(idx_ff) + 1'b1 == line_len_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = S_EMIT_RD;
               end
            end
            S_DRAIN2: begin
               rsp_valid_in = 1'b1;
               rsp_in   = mk_rsp(tld_pkg::KIND_OUT, out_rd_ff, 1'b0, 1'b1);
               state_in = S_IDLE;
            end
            default: begin
               state_in = S_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         in_rp_ff     <= '0;
         in_wp_ff     <= '0;
         in_fill_ff   <= '0;
         out_rp_ff    <= '0;
         out_wp_ff    <= '0;
         out_fill_ff  <= '0;
         line_len_ff  <= '0;
         read_max_ff  <= '0;
         pending_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         in_rp_ff     <= in_rp_in;
         in_wp_ff     <= in_wp_in;
         in_fill_ff   <= in_fill_in;
         out_rp_ff    <= out_rp_in;
         out_wp_ff    <= out_wp_in;
         out_fill_ff  <= out_fill_in;
         line_len_ff  <= line_len_in;
         read_max_ff  <= read_max_in;
         pending_ff   <= pending_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      rsp_ff <= rsp_in;
      idx_ff <= idx_in;
   end

   always_ff @(posedge clock) begin
      if (in_we) begin
         in_ring_ff[in_wp_ff] <= cmd_data.data_byte;
      end
      if (in_re) begin
         in_rd_ff <= in_ring_ff[in_rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (out_we) begin
         out_ring_ff[out_wp_ff] <= out_wd;
      end
      if (out_re) begin
         out_rd_ff <= out_ring_ff[out_rp_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (line_we) begin
         line_ff[line_wa] <= line_wd;
      end
      if (line_re) begin
         line_rd_ff <= line_ff[idx_ff];
      end
   end

`ifndef SYNTHESIS
   a_in_fill: assert property (@(posedge clock) disable iff (reset)
      in_fill_ff <= IFW'(IN_DEPTH)) else $error("input ring overfilled");
   a_out_fill: assert property (@(posedge clock) disable iff (reset)
      out_fill_ff <= OFW'(OUT_DEPTH)) else $error("output ring overfilled");
   a_line_len: assert property (@(posedge clock) disable iff (reset)
      line_len_ff <= read_max_ff) else $error("line longer than read limit");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> $stable(state_ff) && $stable(in_fill_ff))
      else $error("engine advanced while result stalled");
`endif

endmodule

// ----- sv/tty_cooked_line_discipline_top.sv -----
// ----------------------------------------------------------------------------
// tty_cooked_line_discipline_top
// Single cooked-mode terminal: key input ring, output ring and line assembly.
// ----------------------------------------------------------------------------
// Each request transaction yields one or more result transactions, the final
// one marked last. Key and host-write results are registered, with an extra
// state when LF expands to CR LF; a drain result comes from the registered read
// of the output ring. A read steps through each consumed key byte in the input
// ring and each emitted line byte, through the registered reads of the input
// ring and line store memories. A two-entry command queue decouples request
// intake from execution; csr writes are always ready.
module tty_cooked_line_discipline_top #(
   parameter int IN_DEPTH  = tld_pkg::IN_DEPTH_DEF,
   parameter int OUT_DEPTH = tld_pkg::OUT_DEPTH_DEF,
   parameter int LINE_MAX  = tld_pkg::LINE_MAX_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  tld_pkg::tld_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output tld_pkg::tld_rsp_type rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [7:0]           csr_data
);

   tld_pkg::tld_cfg_type cfg_ff, cfg_in;
   tld_pkg::tld_cmd_type cmd_data;
   logic cmd_valid, cmd_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tld_pkg::REG_ECHO_ENABLE:   cfg_in.echo_enable   = csr_data[0];
            tld_pkg::REG_OUT_CRLF:      cfg_in.out_crlf      = csr_data[0];
            tld_pkg::REG_IN_NL_TO_CRNL: cfg_in.in_nl_to_crnl = csr_data[0];
            tld_pkg::REG_EOF_ENABLE:    cfg_in.eof_enable    = csr_data[0];
            tld_pkg::REG_EOF_CHAR:      cfg_in.eof_char      = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.echo_enable   <= 1'b1;
         cfg_ff.out_crlf      <= 1'b1;
         cfg_ff.in_nl_to_crnl <= 1'b1;
         cfg_ff.eof_enable    <= 1'b1;
         cfg_ff.eof_char      <= 8'hFF;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tld_front #(.LINE_MAX(LINE_MAX)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data)
   );

   tld_back #(
      .IN_DEPTH  (IN_DEPTH),
      .OUT_DEPTH (OUT_DEPTH),
      .LINE_MAX  (LINE_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd_data  (cmd_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- dv/tld_scoreboard.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tld_scoreboard
// Watches the request, result and csr channels of the cooked line discipline,
// predicts the result transactions of every request and compares them.
// ----------------------------------------------------------------------------
module tld_scoreboard (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  tld_pkg::tld_req_type req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  tld_pkg::tld_rsp_type rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [7:0]           csr_data,
   output int                   mismatch_count,
   output int                   outstanding,
   output int                   lines_seen
);

   tld_pkg::tld_cfg_type cfg;
   logic [7:0]  key_ring [256];
   logic [7:0]  key_rd, key_wr;
   logic [8:0]  key_fill;
   logic [7:0]  tx_ring [256];
   logic [7:0]  tx_rd, tx_wr;
   logic [8:0]  tx_fill;
   logic [7:0]  line_buf [64];
   logic [6:0]  line_len;
   logic        read_open;
   logic [6:0]  read_cap;
   tld_pkg::tld_rsp_type expected_rsp [$];

   assign outstanding = expected_rsp.size();

   task automatic push_rsp(logic [1:0] kind, logic [7:0] b, logic st);
      tld_pkg::tld_rsp_type r;
      r.result_kind = kind;
      r.out_byte    = b;
      r.status      = st;
      r.last        = 1'b1;
      expected_rsp.push_back(r);
   endtask

   function automatic bit tx_put(logic [7:0] b);
      if (tx_fill >= 9'd256) return 1'b0;
      tx_ring[tx_wr] = b;
      tx_wr++;
      tx_fill++;
      return 1'b1;
   endfunction

   // consume queued keys into the line; return 1 once the line is complete
   function automatic bit line_advance();
      logic [7:0] ch;
      while (line_len < read_cap) begin
         if (key_fill == 9'd0) return 1'b0;
         ch = key_ring[key_rd];
         key_rd++;
         key_fill--;
         if (ch == tld_pkg::CH_BS) begin
            if (line_len > 7'd0) begin
               line_len--;
               continue;
            end
         end else if (ch == tld_pkg::CH_LF) begin
            if (cfg.in_nl_to_crnl && line_len + 7'd1 < read_cap) begin
               line_buf[line_len] = tld_pkg::CH_CR;
               line_len++;
            end
            line_buf[line_len] = tld_pkg::CH_LF;
            line_len++;
         end else begin
            line_buf[line_len] = ch;
            line_len++;
         end
         if (cfg.eof_enable && ch == cfg.eof_char) return 1'b1;
         if (ch == tld_pkg::CH_CR || ch == tld_pkg::CH_LF) return 1'b1;
      end
      return 1'b1;
   endfunction

   task automatic push_line();
      tld_pkg::tld_rsp_type r;
      read_open = 1'b0;
      lines_seen++;
      if (line_len == 7'd0) begin
         push_rsp(tld_pkg::KIND_EMPTY, 8'd0, 1'b0);
         return;
      end
      for (int i = 0; i < line_len; i++) begin
         r.result_kind = tld_pkg::KIND_LINE;
         r.out_byte    = line_buf[i];
         r.status      = 1'b0;
         r.last        = (i + 1 == line_len);
         expected_rsp.push_back(r);
      end
   endtask

   task automatic predict_request(tld_pkg::tld_req_type q);
      bit ok;
      case (q.req_type)
         tld_pkg::OP_KEY: begin
            if (key_fill >= 9'd256) begin
               push_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b1);
            end else begin
               if (cfg.echo_enable) begin
                  if (q.data_byte == tld_pkg::CH_LF && cfg.out_crlf) begin
                     ok = tx_put(tld_pkg::CH_CR);
                     ok = tx_put(tld_pkg::CH_LF);
                  end else begin
                     ok = tx_put(q.data_byte);
                  end
               end
               key_ring[key_wr] = q.data_byte;
               key_wr++;
               key_fill++;
               if (read_open && line_advance()) push_line();
               else push_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b0);
            end
         end
         tld_pkg::OP_HOST: begin
            if (q.data_byte == tld_pkg::CH_LF && cfg.out_crlf && !tx_put(tld_pkg::CH_CR))
               push_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b1);
            else
               push_rsp(tld_pkg::KIND_STATUS, 8'd0, !tx_put(q.data_byte));
         end
         tld_pkg::OP_READ: begin
            if (read_open) begin
               push_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b1);
            end else begin
               read_open = 1'b1;
               read_cap  = (q.read_limit > 7'd64) ? 7'd64 : q.read_limit;
               line_len  = 7'd0;
               if (line_advance()) push_line();
               else push_rsp(tld_pkg::KIND_STATUS, 8'd0, 1'b0);
            end
         end
         default: begin
            if (tx_fill == 9'd0) begin
               push_rsp(tld_pkg::KIND_EMPTY, 8'd0, 1'b0);
            end else begin
               push_rsp(tld_pkg::KIND_OUT, tx_ring[tx_rd], 1'b0);
               tx_rd++;
               tx_fill--;
            end
         end
      endcase
   endtask

   task automatic note_mismatch(string what, tld_pkg::tld_rsp_type want,
                                tld_pkg::tld_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display({"%0t mismatch %s: expected kind %0d byte %02h status %0d last %0d,",
                   " got kind %0d byte %02h status %0d last %0d"},
                  $time, what, want.result_kind, want.out_byte, want.status, want.last,
                  got.result_kind, got.out_byte, got.status, got.last);
   endtask

   always @(posedge clock) begin
      tld_pkg::tld_rsp_type want;
      if (reset) begin
         cfg = '{1'b1, 1'b1, 1'b1, 1'b1, 8'hFF};
         key_rd = 8'd0; key_wr = 8'd0; key_fill = 9'd0;
         tx_rd = 8'd0; tx_wr = 8'd0; tx_fill = 9'd0;
         line_len = 7'd0; read_open = 1'b0; read_cap = 7'd0;
         expected_rsp.delete();
         mismatch_count = 0;
         lines_seen = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               tld_pkg::REG_ECHO_ENABLE:   cfg.echo_enable   = csr_data[0];
               tld_pkg::REG_OUT_CRLF:      cfg.out_crlf      = csr_data[0];
               tld_pkg::REG_IN_NL_TO_CRNL: cfg.in_nl_to_crnl = csr_data[0];
               tld_pkg::REG_EOF_ENABLE:    cfg.eof_enable    = csr_data[0];
               tld_pkg::REG_EOF_CHAR:      cfg.eof_char      = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_request(req_data);
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               want = '0;
               note_mismatch("unexpected transaction", want, rsp_data);
            end else begin
               want = expected_rsp.pop_front();
               if (want.result_kind != rsp_data.result_kind)
                  note_mismatch("result_kind", want, rsp_data);
               else if (want.out_byte != rsp_data.out_byte)
                  note_mismatch("out_byte", want, rsp_data);
               else if (want.status != rsp_data.status)
                  note_mismatch("status", want, rsp_data);
               else if (want.last != rsp_data.last)
                  note_mismatch("last", want, rsp_data);
            end
         end
      end
   end

endmodule

// ----- dv/tty_cooked_line_discipline_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tty_cooked_line_discipline_top_tb
// Drives key, host, read and drain transactions through several register
// settings, with random gaps and stalls; the scoreboard checks every result.
// ----------------------------------------------------------------------------
module tty_cooked_line_discipline_top_tb;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   tld_pkg::tld_req_type req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b1;
   tld_pkg::tld_rsp_type rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [2:0]           csr_index = '0;
   logic [7:0]           csr_data = '0;
   int                   mismatch_count, outstanding, lines_seen;
   int                   requests_sent = 0;
   int                   settings_used = 0;
   bit                   no_gaps = 1'b0;
   int                   rsp_hold = 0;

   always #5 clock = ~clock;

   tty_cooked_line_discipline_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   tld_scoreboard scoreboard (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .mismatch_count(mismatch_count), .outstanding(outstanding),
      .lines_seen(lines_seen)
   );

   // draw a fresh stall length for every accepted result transaction
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) rsp_hold = no_gaps ? 0 : $urandom_range(0, 6);
      else if (rsp_hold > 0) rsp_hold--;
      rsp_stall <= reset ? 1'b0 : (rsp_hold != 0);
   end

   task automatic send(logic [1:0] op, logic [7:0] b, logic [6:0] lim);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data.req_type   <= op;
      req_data.data_byte  <= b;
      req_data.read_limit <= lim;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      requests_sent++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // leave csr_valid high between back-to-back writes; the caller drops it
   task automatic csr_write(logic [2:0] idx, logic [7:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(bit echo, bit crlf, bit nl, bit eof_on, logic [7:0] eof_ch);
      wait_idle();
      csr_write(tld_pkg::REG_ECHO_ENABLE, {7'd0, echo});
      csr_write(tld_pkg::REG_OUT_CRLF, {7'd0, crlf});
      csr_write(tld_pkg::REG_IN_NL_TO_CRNL, {7'd0, nl});
      csr_write(tld_pkg::REG_EOF_ENABLE, {7'd0, eof_on});
      csr_write(tld_pkg::REG_EOF_CHAR, eof_ch);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic random_traffic(int count, logic [7:0] eof_ch);
      int pick, n;
      int done;
      done = 0;
      while (done < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 40) begin
            // typed line: text with some erasures, then a terminator
            n = $urandom_range(0, 12);
            repeat (n) begin
               if ($urandom_range(0, 5) == 0) send(tld_pkg::OP_KEY, tld_pkg::CH_BS, 7'd0);
               else send(tld_pkg::OP_KEY, 8'($urandom_range(8'h20, 8'h7E)), 7'($urandom));
               done++;
            end
            case ($urandom_range(0, 2))
               0: send(tld_pkg::OP_KEY, tld_pkg::CH_LF, 7'd0);
               1: send(tld_pkg::OP_KEY, tld_pkg::CH_CR, 7'd0);
               default: send(tld_pkg::OP_KEY, eof_ch, 7'd0);
            endcase
            done++;
         end else if (pick < 58) begin
            if ($urandom_range(0, 3) == 0)
               send(tld_pkg::OP_READ, 8'($urandom), 7'($urandom));
            else
               send(tld_pkg::OP_READ, 8'($urandom), 7'($urandom_range(0, 20)));
            done++;
         end else if (pick < 80) begin
            send(tld_pkg::OP_DRAIN, 8'($urandom), 7'($urandom));
            done++;
         end else if (pick < 90) begin
            send(tld_pkg::OP_HOST,
                 ($urandom_range(0, 3) == 0) ? tld_pkg::CH_LF : 8'($urandom), 7'($urandom));
            done++;
         end else begin
            send(tld_pkg::OP_KEY, 8'($urandom), 7'($urandom));
            done++;
         end
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners at the reset settings
      configure(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
      send(tld_pkg::OP_READ, 8'd0, 7'd64);      // ring empty, stays pending
      send(tld_pkg::OP_KEY, tld_pkg::CH_LF, 7'd0);
      send(tld_pkg::OP_READ, 8'd0, 7'd0);       // zero limit ends at once
      send(tld_pkg::OP_READ, 8'd0, 7'd127);     // saturates, stays pending
      send(tld_pkg::OP_READ, 8'd0, 7'd5);       // refused while pending
      send(tld_pkg::OP_KEY, tld_pkg::CH_BS, 7'd0);  // erase on empty line
      send(tld_pkg::OP_KEY, 8'h41, 7'd0);
      send(tld_pkg::OP_KEY, 8'h42, 7'd0);
      send(tld_pkg::OP_KEY, tld_pkg::CH_BS, 7'd0);
      send(tld_pkg::OP_KEY, tld_pkg::CH_LF, 7'd0);
      send(tld_pkg::OP_KEY, 8'hFF, 7'd0);
      send(tld_pkg::OP_READ, 8'd0, 7'd1);       // eof byte, limit one
      send(tld_pkg::OP_READ, 8'd0, 7'd1);
      send(tld_pkg::OP_KEY, tld_pkg::CH_LF, 7'd0);  // no room for CR
      send(tld_pkg::OP_HOST, tld_pkg::CH_LF, 7'd0);
      send(tld_pkg::OP_HOST, 8'h00, 7'd0);
      repeat (4) send(tld_pkg::OP_DRAIN, 8'd0, 7'd0);

      // backspace doubling as the end-of-file byte
      configure(1'b0, 1'b0, 1'b0, 1'b1, tld_pkg::CH_BS);
      send(tld_pkg::OP_KEY, tld_pkg::CH_BS, 7'd0);
      send(tld_pkg::OP_READ, 8'd0, 7'd10);
      send(tld_pkg::OP_READ, 8'd0, 7'd10);
      send(tld_pkg::OP_KEY, tld_pkg::CH_LF, 7'd0);
      send(tld_pkg::OP_HOST, tld_pkg::CH_LF, 7'd0);
      repeat (12) send(tld_pkg::OP_DRAIN, 8'd0, 7'd0);

      configure(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
      random_traffic(70, 8'hFF);
      wait_idle();
      no_gaps = 1'b1;
      random_traffic(30, 8'hFF);
      no_gaps = 1'b0;

      configure(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
      random_traffic(40, 8'h00);

      configure(1'b1, 1'b0, 1'b1, 1'b1, 8'h04);
      random_traffic(40, 8'h04);

      configure(1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      random_traffic(40, tld_pkg::CH_CR);

      wait_idle();
      $display("covered %0d request transactions over %0d register settings, %0d lines read",
               requests_sent, settings_used, lines_seen);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("tty_cooked_line_discipline_top_tb: clean");
      end else begin
         $display("tty_cooked_line_discipline_top_tb: errors");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", outstanding);
      $display("tty_cooked_line_discipline_top_tb: errors");
      $finish;
   end

endmodule

// ----- tty_cooked_line_discipline_top.f -----
sv/tld_pkg.sv
sv/tld_front.sv
sv/tld_back.sv
sv/tty_cooked_line_discipline_top.sv
dv/tld_scoreboard.sv
dv/tty_cooked_line_discipline_top_tb.sv
